/* design/adpcm_rle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_rle_pkg
// Shared widths, tables and types of the run-length packed ADPCM encoder.
// ----------------------------------------------------------------------------
package adpcm_rle_pkg;

  localparam int SAMPLE_W = 8;
  localparam int CODE_W   = 4;
  localparam int QBITS_W  = 3;
  localparam int IDX_W    = 7;
  localparam int STEP_W   = 15;
  localparam int VP_W     = 16;   // predictor delta
  localparam int ACC_W    = 18;   // q * step before the >>2
  localparam int REM_W    = 10;   // 4 * |diff|
  localparam int DIV_W    = 17;   // step << 2
  localparam int REP_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [IDX_W-1:0] IdxMax = 7'd88;
  localparam logic [REP_W-1:0] RepFull = 4'd15;

  // quantize_mode values
  localparam logic MODE_DIVIDE   = 1'b0;
  localparam logic MODE_SUBTRACT = 1'b1;

  // register index (paddr[2])
  localparam logic REG_QUANT_MODE = 1'b0;

  localparam logic [STEP_W-1:0] STEP_TABLE [89] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  function automatic logic [STEP_W-1:0] step_lookup(input logic [IDX_W-1:0] idx);
    logic [STEP_W-1:0] s;
    if (idx > IdxMax) begin
      s = STEP_TABLE[IdxMax];
    end else begin
      s = STEP_TABLE[idx];
    end
    return s;
  endfunction

  function automatic logic signed [4:0] idx_adjust(input logic [CODE_W-1:0] code);
    logic signed [4:0] a;
    case (code[QBITS_W-1:0]) inside
      3'd0, 3'd1, 3'd2, 3'd3: a = -5'sd1;
      3'd4:                   a = 5'sd2;
      3'd5:                   a = 5'sd4;
      3'd6:                   a = 5'sd6;
      default:                a = 5'sd8;
    endcase
    return a;
  endfunction

  // quantizer -> top
  typedef struct packed {
    logic                done;
    logic [CODE_W-1:0]   code;
    logic [VP_W-1:0]     vpdiff;
  } quant_res_t;

  // top -> packer
  typedef struct packed {
    logic              push;
    logic [CODE_W-1:0] code;
    logic              last;
  } pack_req_t;

endpackage

/* design/adpcm_rle_quant.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_rle_quant
// Bit-serial quantizer: one quotient bit per cycle, MSB first, with the
// predictor delta accumulated alongside.
// ----------------------------------------------------------------------------
module adpcm_rle_quant
  import adpcm_rle_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       ack_i,
  input  logic                       mode_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [SAMPLE_W-1:0] pred_i,
  input  logic [IDX_W-1:0]           idx_i,
  output logic                       idle_o,
  output quant_res_t                 res_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_STEP  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                 state_q, state_d;
  logic [1:0]                 bit_q, bit_d;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [STEP_W-1:0]          step_q, step_d;
  logic [REM_W-1:0]           rem_q, rem_d;
  logic [ACC_W-1:0]           acc_q, acc_d;
  logic [QBITS_W-1:0]         qb_q, qb_d;
  logic                       sign_q, sign_d;
  logic                       clamp_q, clamp_d;
  logic                       mode_q, mode_d;

  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          mag_full;
  logic [SAMPLE_W-1:0]        mag;
  logic [STEP_W-1:0]          step_lu;
  logic [DIV_W-1:0]           rem_x, dv_div, dv_sub, dv;
  logic                       take;

  always_comb begin
    diff     = {sample_q[SAMPLE_W-1], sample_q} - {pred_i[SAMPLE_W-1], pred_i};
    mag_full = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
    mag      = mag_full[SAMPLE_W-1:0];
    step_lu  = step_lookup(idx_i);

    rem_x  = DIV_W'(rem_q);
    dv_div = DIV_W'(step_q) << bit_q;
    dv_sub = DIV_W'(step_q >> (2'd2 - bit_q));
    if (mode_q == MODE_SUBTRACT) begin
      dv   = dv_sub;
      take = rem_x > dv_sub;
    end else begin
      dv   = dv_div;
      // past the clamp every bit is taken: q = 7, delta sum = 7 * step
      take = clamp_q | (rem_x >= dv_div);
    end
  end

  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    step_d  = step_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    qb_d    = qb_q;
    sign_d  = sign_q;
    clamp_d = clamp_q;
    mode_d  = mode_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        step_d  = step_lu;
        sign_d  = diff[SAMPLE_W];
        mode_d  = mode_i;
        clamp_d = {{(STEP_W+1-SAMPLE_W){1'b0}}, mag} >= {step_lu, 1'b0};
        rem_d   = (mode_i == MODE_SUBTRACT) ? REM_W'(mag) : {mag, 2'b00};
        acc_d   = '0;
        qb_d    = '0;
        bit_d   = 2'd2;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (take) begin
          rem_d = REM_W'(rem_x - dv);
          acc_d = acc_q + ACC_W'(dv);
          qb_d  = qb_q | (QBITS_W'(1) << bit_q);
        end
        bit_d = bit_q - 2'd1;
        if (bit_q == 2'd0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ack_i) begin
          state_d = start_i ? ST_SETUP : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sample_q <= sample_i;
    end
    step_q  <= step_d;
    rem_q   <= rem_d;
    acc_q   <= acc_d;
    qb_q    <= qb_d;
    sign_q  <= sign_d;
    clamp_q <= clamp_d;
    mode_q  <= mode_d;
  end

  assign idle_o       = (state_q == ST_IDLE);
  assign res_o.done   = (state_q == ST_DONE);
  assign res_o.code   = {sign_q, qb_q};
  assign res_o.vpdiff = (mode_q == MODE_SUBTRACT) ? acc_q[VP_W-1:0] : acc_q[ACC_W-1:2];

endmodule

/* design/adpcm_rle_pack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_rle_pack
// Run-length packer with a two-entry output queue.
// ----------------------------------------------------------------------------
module adpcm_rle_pack
  import adpcm_rle_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pack_req_t         req_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] packed_byte_o,
  output logic              run_last_o
);

  logic [CODE_W-1:0] run_code_q, run_code_d;
  logic [REP_W-1:0]  run_rep_q, run_rep_d;
  logic              run_open_q, run_open_d;

  logic [BYTE_W-1:0] ent_byte_q [2];
  logic              ent_last_q [2];
  logic [1:0]        cnt_q;
  logic              pop;

  logic              e0_vld, e1_vld;
  logic [BYTE_W-1:0] e0_byte, e1_byte;

  assign pop     = out_valid_o & ~out_stall_i;
  assign ready_o = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & pop);

  always_comb begin
    run_code_d = run_code_q;
    run_rep_d  = run_rep_q;
    run_open_d = run_open_q;
    e0_vld     = 1'b0;
    e0_byte    = '0;
    e1_vld     = 1'b0;
    e1_byte    = '0;
    if (!run_open_q) begin
      run_code_d = req_i.code;
      run_rep_d  = '0;
      run_open_d = 1'b1;
    end else if (req_i.code == run_code_q) begin
      if (run_rep_q == RepFull - 4'd1) begin
        // run full: flush at once
        e0_vld     = 1'b1;
        e0_byte    = {run_code_q, RepFull};
        run_open_d = 1'b0;
        run_rep_d  = '0;
      end else begin
        run_rep_d = run_rep_q + 4'd1;
      end
    end else begin
      e0_vld     = 1'b1;
      e0_byte    = {run_code_q, run_rep_q};
      run_code_d = req_i.code;
      run_rep_d  = '0;
    end
    if (req_i.last) begin
      e1_vld     = run_open_d;
      e1_byte    = {run_code_d, run_rep_d};
      run_code_d = '0;
      run_rep_d  = '0;
      run_open_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_code_q <= '0;
      run_rep_q  <= '0;
      run_open_q <= 1'b0;
      cnt_q      <= '0;
    end else if (req_i.push) begin
      run_code_q <= run_code_d;
      run_rep_q  <= run_rep_d;
      run_open_q <= run_open_d;
      cnt_q      <= 2'(e0_vld) + 2'(e1_vld);
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // push only happens when the queue is empty or drains this cycle
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      if (e0_vld) begin
        ent_byte_q[0] <= e0_byte;
        ent_last_q[0] <= req_i.last & ~e1_vld;
        ent_byte_q[1] <= e1_byte;
        ent_last_q[1] <= 1'b1;
      end else begin
        ent_byte_q[0] <= e1_byte;
        ent_last_q[0] <= 1'b1;
        ent_byte_q[1] <= e1_byte;
        ent_last_q[1] <= 1'b1;
      end
    end else if (pop) begin
      ent_byte_q[0] <= ent_byte_q[1];
      ent_last_q[0] <= ent_last_q[1];
    end
  end

  assign out_valid_o   = (cnt_q != 2'd0);
  assign packed_byte_o = ent_byte_q[0];
  assign run_last_o    = ent_last_q[0];

endmodule

/* design/adpcm_run_length_encoder.sv */
`timescale 1ns / 1ps
// Sample flow: each sample runs through the bit-serial quantizer (setup,
//   three quotient-bit steps, finish), and a new sample is taken while the
//   quantizer is idle or as it finishes; finish waits while the two-entry
//   output queue still holds bytes that are not taken.
// Reset: rst_ni is asynchronous, active low; it clears predictor, step
//   index, pending run, quantize mode and the output queue.
// ----------------------------------------------------------------------------
// adpcm_run_length_encoder
// IMA-style 4-bit ADPCM encoder with run-length packed byte output.
// ----------------------------------------------------------------------------
module adpcm_run_length_encoder
  import adpcm_rle_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // sample channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       block_end_i,
  // byte channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [BYTE_W-1:0]          packed_byte_o,
  output logic                       run_last_o,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  logic                       mode_q;
  logic signed [SAMPLE_W-1:0] pred_q, pred_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic                       last_q;

  logic                       q_idle;
  quant_res_t                 q_res;
  pack_req_t                  p_req;
  logic                       p_ready;
  logic                       fire, start;

  logic signed [ACC_W-1:0]    psum;
  logic signed [SAMPLE_W:0]   nidx;

  assign fire       = q_res.done & p_ready;
  assign in_stall_o = ~(q_idle | fire);
  assign start      = in_valid_i & ~in_stall_o;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUANT_MODE) ? DATA_W'(mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DIVIDE;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_QUANT_MODE)) begin
      mode_q <= pwdata[0];
    end
  end

  // predictor and step index update
  always_comb begin
    if (q_res.code[CODE_W-1]) begin
      psum = ACC_W'(pred_q) - $signed({2'b00, q_res.vpdiff});
    end else begin
      psum = ACC_W'(pred_q) + $signed({2'b00, q_res.vpdiff});
    end
    if (psum > 18'sd127) begin
      pred_d = 8'sd127;
    end else if (psum < -18'sd128) begin
      pred_d = -8'sd128;
    end else begin
      pred_d = psum[SAMPLE_W-1:0];
    end

    nidx = $signed({2'b00, idx_q}) + (SAMPLE_W+1)'(idx_adjust(q_res.code));
    if (nidx < 0) begin
      idx_d = '0;
    end else if (nidx > $signed({2'b00, IdxMax})) begin
      idx_d = IdxMax;
    end else begin
      idx_d = nidx[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q <= '0;
      idx_q  <= '0;
      last_q <= 1'b0;
    end else begin
      if (fire) begin
        pred_q <= last_q ? '0 : pred_d;
        idx_q  <= last_q ? '0 : idx_d;
      end
      if (start) begin
        last_q <= block_end_i;
      end
    end
  end

  assign p_req.push = fire;
  assign p_req.code = q_res.code;
  assign p_req.last = last_q;

  adpcm_rle_quant u_quant (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .ack_i    (fire),
    .mode_i   (mode_q),
    .sample_i (sample_i),
    .pred_i   (pred_q),
    .idx_i    (idx_q),
    .idle_o   (q_idle),
    .res_o    (q_res)
  );

  adpcm_rle_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (p_req),
    .ready_o       (p_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packed_byte_o (packed_byte_o),
    .run_last_o    (run_last_o)
  );

endmodule

/* design/adpcm_rle_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_rle_chk
// Port-level checks of the ADPCM run-length encoder, bound to the top level.
// ----------------------------------------------------------------------------
module adpcm_rle_chk
  import adpcm_rle_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [BYTE_W-1:0] packed_byte_o,
  input logic              run_last_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i & ~in_stall_o;

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(packed_byte_o)
                                   && $stable(run_last_o))
    else $error("stalled output changed");

  // the quantizer is busy through its setup and quotient-bit steps after a sample transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o ##1 in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("sample taken while quantizer busy");

  // no byte is valid as reset is released
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // queue is empty while reset is held
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind adpcm_run_length_encoder adpcm_rle_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .packed_byte_o (packed_byte_o),
  .run_last_o    (run_last_o)
);
